// ----- sv/uer_pkg.sv -----
// ----------------------------------------------------------------------------
// uer_pkg: shared definitions of the ultrasonic echo ranger
// Types, register codes, reset values and counter helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

	localparam int CNT_W  = 16;
	localparam int WIDE_W = (CNT_W > 16) ? CNT_W : 16;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam int DIV_STEPS = 14;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIMEOUT   = 3'd0,
		CFG_SETTLE    = 3'd1,
		CFG_TRIGGER   = 3'd2,
		CFG_PULSE_MIN = 3'd3,
		CFG_PULSE_MAX = 3'd4,
		CFG_MIN_CM    = 3'd5,
		CFG_MAX_CM    = 3'd6
	} cfg_idx_t;

	localparam logic [15:0] RST_TIMEOUT   = 16'd5000;
	localparam logic [15:0] RST_SETTLE    = 16'd200;
	localparam logic [7:0]  RST_TRIGGER   = 8'd5;
	localparam logic [15:0] RST_PULSE_MIN = 16'd115;
	localparam logic [15:0] RST_PULSE_MAX = 16'd18500;
	localparam logic [9:0]  RST_MIN_CM    = 10'd2;
	localparam logic [9:0]  RST_MAX_CM    = 10'd300;

	typedef struct packed {
		logic [15:0] timeout_us;
		logic [15:0] settle_us;
		logic [7:0]  trigger_us;
		logic [15:0] pulse_min_us;
		logic [15:0] pulse_max_us;
		logic [9:0]  min_cm;
		logic [9:0]  max_cm;
	} cfg_t;

	typedef enum logic [1:0] {
		PH_TRIGGER = 2'd0,
		PH_LISTEN  = 2'd1,
		PH_SETTLE  = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		SQ_IDLE = 3'd0,
		SQ_MUL  = 3'd1,
		SQ_DGO  = 3'd2,
		SQ_DIV  = 3'd3,
		SQ_OUT  = 3'd4
	} seq_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [CNT_W-1:0] len_limit(input logic [15:0] len);
		logic [WIDE_W-1:0] l;
		logic [WIDE_W-1:0] m;
		l = WIDE_W'(len);
		m = WIDE_W'(CNT_MAX);
		if (l == '0) begin
			l = WIDE_W'(1);
		end
		if (l > m) begin
			l = m;
		end
		return CNT_W'(l);
	endfunction

endpackage

`default_nettype wire

// ----- sv/uer_cfg.sv -----
// ----------------------------------------------------------------------------
// uer_cfg: configuration registers
// Holds the seven timing and range registers written through the write port.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [uer_pkg::CFG_DATA_W-1:0] cfg_data,
	output uer_pkg::cfg_t                       cfg
);

	uer_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_us   <= uer_pkg::RST_TIMEOUT;
			cfg_q.settle_us    <= uer_pkg::RST_SETTLE;
			cfg_q.trigger_us   <= uer_pkg::RST_TRIGGER;
			cfg_q.pulse_min_us <= uer_pkg::RST_PULSE_MIN;
			cfg_q.pulse_max_us <= uer_pkg::RST_PULSE_MAX;
			cfg_q.min_cm       <= uer_pkg::RST_MIN_CM;
			cfg_q.max_cm       <= uer_pkg::RST_MAX_CM;
		end else if (cfg_we) begin
			unique case (uer_pkg::cfg_idx_t'(cfg_index))
				uer_pkg::CFG_TIMEOUT:   cfg_q.timeout_us   <= cfg_data;
				uer_pkg::CFG_SETTLE:    cfg_q.settle_us    <= cfg_data;
				uer_pkg::CFG_TRIGGER:   cfg_q.trigger_us   <= cfg_data[7:0];
				uer_pkg::CFG_PULSE_MIN: cfg_q.pulse_min_us <= cfg_data;
				uer_pkg::CFG_PULSE_MAX: cfg_q.pulse_max_us <= cfg_data;
				uer_pkg::CFG_MIN_CM:    cfg_q.min_cm       <= cfg_data[9:0];
				uer_pkg::CFG_MAX_CM:    cfg_q.max_cm       <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- sv/uer_div.sv -----
// ----------------------------------------------------------------------------
// uer_div: iterative restoring divider
// One compare and subtract per cycle; the quotient is known to fit in
// fourteen bits, so only that many steps are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [16:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [13:0]      quotient
);

	logic [16:0]                   rem_q;
	logic [13:0]                   low_q;
	logic [16:0]                   dsr_q;
	logic [uer_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [17:0]                   trial;
	logic [17:0]                   diff;
	logic                          fits;

	assign trial = {rem_q, low_q[13]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == uer_pkg::DIV_CNT_W'(uer_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[30:14];
			low_q <= dividend[13:0];
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[16:0] : trial[16:0];
			low_q <= {low_q[12:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = low_q;

endmodule

`default_nettype wire

// ----- sv/ultrasonic_echo_ranger.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: ping sonar controller on one-microsecond ticks
// Drives the trigger pulse, times the echo and maps its width onto distance.
// ----------------------------------------------------------------------------
// Each item on the s_ channel is one microsecond tick carrying the sampled
// echo level; each tick yields exactly one item on the m_ channel with the
// trigger level, the stored distance in sixteenths of a centimetre and the
// new-distance and timeout flags. Configuration is written through cfg_we,
// cfg_index and cfg_data; the user must do so only while no tick is in
// flight, as the block does not enforce it. A tick that does not complete
// an echo inside the mapped range passes the phase update on acceptance
// and the output load. A tick that finishes an echo strictly between the
// two pulse limits also passes the multiply and divider start states, the
// fourteen one-bit steps of the restoring divider and its done strobe. The
// input is not ready while a tick is being processed.
// Reset puts the block in the trigger phase with all counters and the
// stored distance cleared and the registers at their default values.
// If the receiver stalls, the result stays in the output register; the next
// tick is still accepted and processed, its result waits until the held one
// has been taken, and the tick after that waits at the input.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// bit 0: echo_level
	input  wire logic [7:0]                     s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// bit 0: trigger_level, bits 14:1: distance_q4, bit 15: new_distance,
	// bit 16: timed_out
	output logic [23:0]                         m_tdata,
	input  wire logic                           cfg_we,
	input  wire logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [uer_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = uer_pkg::CNT_W;
	localparam int WW = uer_pkg::WIDE_W;

	uer_pkg::cfg_t   cfg;
	uer_pkg::seq_t   seq_q;
	uer_pkg::seq_t   seq_n;
	uer_pkg::phase_t phase_q;
	uer_pkg::phase_t phase_n;

	logic [CW-1:0] pc_q;
	logic [CW-1:0] pc_n;
	logic [1:0]    edge_q;
	logic [1:0]    edge_n;
	logic [CW-1:0] ew_q;
	logic [CW-1:0] ew_n;
	logic          last_q;
	logic          last_n;
	logic [13:0]   dist_q;

	logic          trig_n;
	logic          fresh_n;
	logic          gave_up_n;
	logic          done_n;

	logic          res_trig_q;
	logic          res_fresh_q;
	logic          res_to_q;

	logic [15:0]   diff_q;
	logic [29:0]   mag_q;
	logic [29:0]   prod;

	logic [13:0]   lo_q4;
	logic [13:0]   hi_q4;
	logic          span_neg;
	logic [13:0]   span_mag;
	logic [15:0]   den;
	logic          w_le_min;
	logic          w_ge_max;
	logic [WW-1:0] w_wide;

	logic          accept;
	logic          out_load;
	logic          div_start;
	logic          div_busy;
	logic          div_done;
	logic [13:0]   div_q;
	logic [31:0]   div_dividend;
	logic [16:0]   div_divisor;
	logic          m_tvalid_q;
	logic [23:0]   m_tdata_q;

	uer_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	uer_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	assign lo_q4    = {cfg.min_cm, 4'b0000};
	assign hi_q4    = {cfg.max_cm, 4'b0000};
	assign span_neg = hi_q4 < lo_q4;
	assign span_mag = span_neg ? (lo_q4 - hi_q4) : (hi_q4 - lo_q4);
	assign den      = cfg.pulse_max_us - cfg.pulse_min_us;
	assign prod     = {14'b0, diff_q} * {16'b0, span_mag};

	assign div_dividend = {1'b0, mag_q, 1'b0} + {16'b0, den};
	assign div_divisor  = {den, 1'b0};

	// Tick update of the phase machine, applied when an item is accepted.
	always_comb begin
		phase_n   = phase_q;
		pc_n      = pc_q;
		edge_n    = edge_q;
		ew_n      = ew_q;
		last_n    = last_q;
		trig_n    = 1'b0;
		fresh_n   = 1'b0;
		gave_up_n = 1'b0;
		done_n    = 1'b0;
		unique case (phase_q)
			uer_pkg::PH_LISTEN: begin
				pc_n = uer_pkg::sat_inc(pc_q);
				if (edge_q == 2'd1) begin
					ew_n = uer_pkg::sat_inc(ew_q);
				end
				if (s_tdata[0] != last_q) begin
					if (edge_q == 2'd0) begin
						edge_n = 2'd1;
						ew_n   = '0;
					end else begin
						edge_n = 2'd2;
						done_n = 1'b1;
					end
				end
				last_n = s_tdata[0];
				if (done_n) begin
					fresh_n = ew_n != '0;
					phase_n = uer_pkg::PH_SETTLE;
					pc_n    = '0;
				end else if (pc_n >= uer_pkg::len_limit(cfg.timeout_us)) begin
					gave_up_n = 1'b1;
					phase_n   = uer_pkg::PH_SETTLE;
					pc_n      = '0;
				end
			end
			uer_pkg::PH_SETTLE: begin
				pc_n = uer_pkg::sat_inc(pc_q);
				if (pc_n >= uer_pkg::len_limit(cfg.settle_us)) begin
					phase_n = uer_pkg::PH_TRIGGER;
					pc_n    = '0;
					edge_n  = 2'd0;
					ew_n    = '0;
				end
			end
			default: begin
				if (pc_q == '0) begin
					edge_n = 2'd0;
					ew_n   = '0;
				end
				phase_n = uer_pkg::PH_TRIGGER;
				trig_n  = 1'b1;
				pc_n    = uer_pkg::sat_inc(pc_q);
				if (pc_n >= uer_pkg::len_limit({8'b0, cfg.trigger_us})) begin
					phase_n = uer_pkg::PH_LISTEN;
					pc_n    = '0;
					last_n  = 1'b0;
				end
			end
		endcase
	end

	assign w_wide   = WW'(ew_n);
	assign w_le_min = w_wide <= WW'(cfg.pulse_min_us);
	assign w_ge_max = w_wide >= WW'(cfg.pulse_max_us);

	always_comb begin
		seq_n = seq_q;
		unique case (seq_q)
			uer_pkg::SQ_IDLE: begin
				if (s_tvalid) begin
					if (fresh_n && !w_le_min && !w_ge_max) begin
						seq_n = uer_pkg::SQ_MUL;
					end else begin
						seq_n = uer_pkg::SQ_OUT;
					end
				end
			end
			uer_pkg::SQ_MUL: seq_n = uer_pkg::SQ_DGO;
			uer_pkg::SQ_DGO: seq_n = uer_pkg::SQ_DIV;
			uer_pkg::SQ_DIV: begin
				if (div_done) begin
					seq_n = uer_pkg::SQ_OUT;
				end
			end
			uer_pkg::SQ_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					seq_n = uer_pkg::SQ_IDLE;
				end
			end
			default: seq_n = uer_pkg::SQ_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (seq_q)
			uer_pkg::SQ_IDLE: s_tready  = 1'b1;
			uer_pkg::SQ_DGO:  div_start = 1'b1;
			uer_pkg::SQ_OUT:  out_load  = !m_tvalid_q || m_tready;
			default: begin
			end
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q      <= uer_pkg::SQ_IDLE;
			phase_q    <= uer_pkg::PH_TRIGGER;
			pc_q       <= '0;
			edge_q     <= 2'd0;
			ew_q       <= '0;
			last_q     <= 1'b0;
			dist_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			seq_q <= seq_n;
			if (accept) begin
				phase_q <= phase_n;
				pc_q    <= pc_n;
				edge_q  <= edge_n;
				ew_q    <= ew_n;
				last_q  <= last_n;
				if (fresh_n && (w_le_min || w_ge_max)) begin
					dist_q <= w_le_min ? lo_q4 : hi_q4;
				end
			end
			if (div_done) begin
				dist_q <= span_neg ? (lo_q4 - div_q) : (lo_q4 + div_q);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_trig_q  <= trig_n;
			res_fresh_q <= fresh_n;
			res_to_q    <= gave_up_n;
			diff_q      <= 16'(w_wide - WW'(cfg.pulse_min_us));
		end
		if (seq_q == uer_pkg::SQ_MUL) begin
			mag_q <= prod;
		end
		if (out_load) begin
			m_tdata_q <= {7'b0, res_to_q, res_fresh_q, dist_q, res_trig_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> seq_q == uer_pkg::SQ_DIV)
		else $error("divider finished outside the divide state");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> div_busy)
		else $error("divider not running after start");

	a_flags_apart: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[15] && m_tdata[16]) && !(m_tdata[0] && m_tdata[16]))
		else $error("result carries conflicting flags");

	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q != uer_pkg::SQ_IDLE) |=> $stable(phase_q))
		else $error("phase changed while a tick was in flight");

endmodule

`default_nettype wire

// ----- verif/ultrasonic_echo_ranger_test.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_test: self-checking testbench of the echo ranger
// Sends one microsecond tick per item and predicts the output of every tick.
// Each ping is built from the predicted phase, and in the random test its
// echo delay and width are random. Receiver stalls and sender gaps are
// random. The distance mapping, timeouts, zero and extreme register values
// and back-pressure are each covered by a named test.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger_test;

	localparam int IDLE_LIMIT = 5000;
	localparam int MAX_SHOWN  = 100;

	typedef struct packed {
		uer_pkg::phase_t ph;
		logic [31:0]     pc;
		logic [1:0]      edges;
		logic [31:0]     width;
		logic            last;
		logic [13:0]     distance;
	} ranger_state_t;

	typedef struct packed {
		logic        trig;
		logic [13:0] distance;
		logic        fresh;
		logic        gave_up;
	} ranger_out_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [7:0]                     s_tdata   = '0;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [23:0]                    m_tdata;
	logic                           cfg_we    = 1'b0;
	uer_pkg::cfg_idx_t              cfg_index = uer_pkg::CFG_TIMEOUT;
	logic [uer_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	uer_pkg::cfg_t regs;
	ranger_state_t rs;
	ranger_out_t   ticks_due[$];
	int            errors      = 0;
	int            n_sent      = 0;
	int            n_checked   = 0;
	int            idle_cycles = 0;
	int            hold_cycles = 0;
	bit            quiet       = 1'b0;

	ultrasonic_echo_ranger dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v >= 32'(uer_pkg::CNT_MAX)) ? 32'(uer_pkg::CNT_MAX) : v + 1;
	endfunction

	function automatic logic [31:0] phase_len(input logic [31:0] len);
		if (len == 0) begin
			return 1;
		end
		return (len > 32'(uer_pkg::CNT_MAX)) ? 32'(uer_pkg::CNT_MAX) : len;
	endfunction

	function automatic logic [13:0] width_to_q4(input logic [31:0] w);
		longint lo, hi, num, den, mag, q;
		lo = 16 * longint'(regs.min_cm);
		hi = 16 * longint'(regs.max_cm);
		if (w <= regs.pulse_min_us) begin
			return 14'(lo);
		end
		if (w >= regs.pulse_max_us) begin
			return 14'(hi);
		end
		num = (longint'(w) - longint'(regs.pulse_min_us)) * (hi - lo);
		den = longint'(regs.pulse_max_us) - longint'(regs.pulse_min_us);
		mag = (num < 0) ? -num : num;
		// Rounding is half away from zero, also for a falling slope.
		q = (2 * mag + den) / (2 * den);
		return 14'((num < 0) ? lo - q : lo + q);
	endfunction

	function automatic ranger_out_t step_ranger(input logic echo);
		ranger_out_t r;
		bit done;
		r = '0;
		done = 1'b0;
		case (rs.ph)
			uer_pkg::PH_LISTEN: begin
				rs.pc = bump(rs.pc);
				if (rs.edges == 1) begin
					rs.width = bump(rs.width);
				end
				if (echo != rs.last) begin
					if (rs.edges == 0) begin
						rs.edges = 1;
						rs.width = 0;
					end else begin
						rs.edges = 2;
						done = 1'b1;
					end
				end
				rs.last = echo;
				// A finished echo wins over a timeout on the same tick.
				if (done) begin
					if (rs.width != 0) begin
						rs.distance = width_to_q4(rs.width);
						r.fresh = 1'b1;
					end
					rs.ph = uer_pkg::PH_SETTLE;
					rs.pc = 0;
				end else if (regs.timeout_us == 0 ||
					rs.pc >= phase_len(32'(regs.timeout_us))) begin
					r.gave_up = 1'b1;
					rs.ph = uer_pkg::PH_SETTLE;
					rs.pc = 0;
				end
			end
			uer_pkg::PH_SETTLE: begin
				rs.pc = bump(rs.pc);
				if (rs.pc >= phase_len(32'(regs.settle_us))) begin
					rs.ph = uer_pkg::PH_TRIGGER;
					rs.pc = 0;
					rs.edges = 0;
					rs.width = 0;
				end
			end
			default: begin
				if (rs.pc == 0) begin
					rs.edges = 0;
					rs.width = 0;
				end
				rs.ph = uer_pkg::PH_TRIGGER;
				r.trig = 1'b1;
				rs.pc = bump(rs.pc);
				if (rs.pc >= phase_len(32'(regs.trigger_us))) begin
					rs.ph = uer_pkg::PH_LISTEN;
					rs.pc = 0;
					rs.last = 1'b0;
				end
			end
		endcase
		r.distance = rs.distance;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		errors++;
		if (errors <= MAX_SHOWN) begin
			$display("mismatch in %s at result %0d: got %0d, expected %0d",
				what, n_checked, got, want);
		end
	endtask

	task automatic check_result(input logic [23:0] word);
		ranger_out_t want;
		n_checked++;
		if (ticks_due.size() == 0) begin
			report_mismatch("unexpected result", word, 0);
			return;
		end
		want = ticks_due.pop_front();
		if (word[0] !== want.trig) begin
			report_mismatch("trigger_level", word[0], want.trig);
		end
		if (word[14:1] !== want.distance) begin
			report_mismatch("distance_q4", word[14:1], want.distance);
		end
		if (word[15] !== want.fresh) begin
			report_mismatch("new_distance", word[15], want.fresh);
		end
		if (word[16] !== want.gave_up) begin
			report_mismatch("timed_out", word[16], want.gave_up);
		end
	endtask

	task automatic send_tick(input logic echo);
		int gap;
		gap = quiet ? 0 : $urandom_range(17, 0);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, echo};
		do @(posedge clk); while (!s_tready);
		ticks_due.push_back(step_ranger(echo));
		n_sent++;
	endtask

	// A negative width gives a noisy echo line, a zero width no echo at all.
	// A non-negative settle count stops the ping early inside its settle wait.
	task automatic send_ping(input int delay, input int width, input int settle_ticks);
		int t, n;
		logic echo;
		while (rs.ph != uer_pkg::PH_TRIGGER) begin
			send_tick(1'($urandom_range(1, 0)));
		end
		while (rs.ph == uer_pkg::PH_TRIGGER) begin
			send_tick(1'($urandom_range(1, 0)));
		end
		t = 0;
		while (rs.ph == uer_pkg::PH_LISTEN) begin
			if (width < 0) begin
				echo = 1'($urandom_range(1, 0));
			end else begin
				echo = (width > 0 && t >= delay && t < delay + width);
			end
			send_tick(echo);
			t++;
		end
		n = 0;
		while (rs.ph == uer_pkg::PH_SETTLE && (settle_ticks < 0 || n < settle_ticks)) begin
			send_tick(1'($urandom_range(1, 0)));
			n++;
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (ticks_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic set_reg(input uer_pkg::cfg_idx_t idx, input int unsigned value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(value);
		case (idx)
			uer_pkg::CFG_TIMEOUT:   regs.timeout_us = 16'(value);
			uer_pkg::CFG_SETTLE:    regs.settle_us = 16'(value);
			uer_pkg::CFG_TRIGGER:   regs.trigger_us = 8'(value);
			uer_pkg::CFG_PULSE_MIN: regs.pulse_min_us = 16'(value);
			uer_pkg::CFG_PULSE_MAX: regs.pulse_max_us = 16'(value);
			uer_pkg::CFG_MIN_CM:    regs.min_cm = 10'(value);
			uer_pkg::CFG_MAX_CM:    regs.max_cm = 10'(value);
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input int unsigned to, input int unsigned se,
		input int unsigned tr, input int unsigned pmin, input int unsigned pmax,
		input int unsigned mn, input int unsigned mx);
		wait_drained();
		set_reg(uer_pkg::CFG_TIMEOUT, to);
		set_reg(uer_pkg::CFG_SETTLE, se);
		set_reg(uer_pkg::CFG_TRIGGER, tr);
		set_reg(uer_pkg::CFG_PULSE_MIN, pmin);
		set_reg(uer_pkg::CFG_PULSE_MAX, pmax);
		set_reg(uer_pkg::CFG_MIN_CM, mn);
		set_reg(uer_pkg::CFG_MAX_CM, mx);
	endtask

	function automatic int unsigned pick_cm();
		case ($urandom_range(3, 0))
			0: return 0;
			1: return 1023;
			default: return $urandom_range(1023, 0);
		endcase
	endfunction

	task automatic test_defaults();
		send_ping(1, 118, 0);
	endtask

	task automatic test_mapping();
		int rising[7] = '{1, 2, 3, 7, 11, 12, 16};
		int falling[3] = '{3, 7, 11};
		int flat[3] = '{5, 6, 12};
		configure(24, 1, 1, 2, 12, 0, 1023);
		foreach (rising[i]) begin
			send_ping(i % 3, rising[i], -1);
		end
		configure(24, 0, 2, 2, 12, 1023, 0);
		foreach (falling[i]) begin
			send_ping(1, falling[i], -1);
		end
		configure(24, 1, 1, 10, 10, 100, 200);
		send_ping(0, 10, -1);
		send_ping(0, 11, -1);
		configure(24, 1, 1, 12, 6, 100, 200);
		foreach (flat[i]) begin
			send_ping(0, flat[i], -1);
		end
		send_ping(0, 13, -1);
		// Widths that fall exactly halfway between two sixteenths.
		configure(8, 1, 1, 0, 32, 0, 1);
		send_ping(0, 1, -1);
		send_ping(0, 3, -1);
		configure(8, 1, 1, 0, 32, 1, 0);
		send_ping(0, 1, -1);
		send_ping(0, 3, -1);
	endtask

	task automatic test_timeouts();
		configure(12, 2, 3, 2, 30, 5, 400);
		send_ping(0, 0, -1);
		send_ping(3, 40, -1);
		send_ping(0, 11, -1);
		send_ping(0, 12, -1);
		configure(0, 0, 0, 2, 30, 5, 400);
		send_ping(0, 0, -1);
		send_ping(0, 3, -1);
		configure(30, 1, 64, 2, 30, 5, 400);
		send_ping(1, 8, -1);
	endtask

	task automatic test_extremes();
		configure(80, 1, 1, 0, 65535, 0, 1023);
		send_ping(0, 60, -1);
		configure(20, 65535, 1, 3, 15, 1023, 1023);
		send_ping(1, 6, 5);
		configure(20, 2, 1, 65535, 65535, 7, 9);
		send_ping(0, 5, -1);
	endtask

	task automatic test_backpressure();
		configure(25, 1, 2, 2, 20, 10, 90);
		hold_cycles = 300;
		quiet = 1'b1;
		repeat (2) send_ping(1, 7, -1);
		quiet = 1'b0;
		wait_drained();
		send_ping(2, 9, -1);
		wait_drained();
	endtask

	task automatic test_random();
		int start, pings, kind;
		int unsigned to, pmin, pmax;
		start = n_sent;
		pings = 0;
		while (n_sent - start < 100) begin
			if (pings % 2 == 0) begin
				to = ($urandom_range(15, 0) == 0) ? 0 : $urandom_range(24, 1);
				pmin = $urandom_range(12, 0);
				if ($urandom_range(5, 0) == 0) begin
					pmax = $urandom_range(pmin, 0);
				end else begin
					pmax = $urandom_range(28, pmin + 1);
				end
				configure(to, $urandom_range(3, 0), $urandom_range(3, 0), pmin, pmax,
					pick_cm(), pick_cm());
			end
			kind = $urandom_range(19, 0);
			if (kind < 14) begin
				send_ping($urandom_range(4, 0), $urandom_range(regs.timeout_us + 4, 1), -1);
			end else if (kind < 17) begin
				send_ping(0, -1, -1);
			end else begin
				send_ping(0, 0, -1);
			end
			if ($urandom_range(9, 0) == 0) begin
				wait_drained();
			end
			pings++;
		end
	endtask

	initial begin
		logic [23:0] got;
		int stall;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end
			stall = quiet ? 0 : $urandom_range(17, 0);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = m_tdata;
			check_result(got);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		regs = '{timeout_us: uer_pkg::RST_TIMEOUT, settle_us: uer_pkg::RST_SETTLE,
			trigger_us: uer_pkg::RST_TRIGGER, pulse_min_us: uer_pkg::RST_PULSE_MIN,
			pulse_max_us: uer_pkg::RST_PULSE_MAX, min_cm: uer_pkg::RST_MIN_CM,
			max_cm: uer_pkg::RST_MAX_CM};
		rs = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_defaults();
		test_mapping();
		test_timeouts();
		test_extremes();
		test_backpressure();
		test_random();
		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
